@@ hw/rtl/glyph_column_generator_assert.svh @@
// assertion macros of the glyph column generator, used by gcg_back
`ifndef GLYPH_COLUMN_GENERATOR_ASSERT_SVH
`define GLYPH_COLUMN_GENERATOR_ASSERT_SVH

// checked on every rising edge outside reset
`define GCG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge, reset included
`define GCG_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/gcg_pkg.sv @@
// types, constants and font table of the glyph column generator
`timescale 1ns / 1ps

package gcg_pkg;

  // columns allowed per string in double-height mode
  localparam int LINE_COLUMNS = 128;
  // glyph columns per character, spacer column not included
  localparam int GLYPH_WIDTH  = 5;
  // rows of one glyph column
  localparam int GLYPH_ROWS   = 7;
  // column counter, wide enough to hold LINE_COLUMNS itself
  localparam int CNT_W        = (LINE_COLUMNS > 255) ? 9 : 8;
  // column pointer within a character, spacer included
  localparam int COL_W        = $clog2(GLYPH_WIDTH + 1);
  // queue between front and back
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QLVL_W       = $clog2(QUEUE_DEPTH + 1);

  typedef logic [GLYPH_ROWS-1:0] glyph_col_t;
  typedef glyph_col_t [GLYPH_WIDTH-1:0] glyph_t;

  // input item
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_string;
  } char_item_t;

  // result item
  typedef struct packed {
    logic [7:0] low_byte;
    logic [7:0] high_byte;
    logic [6:0] column_index;
    logic       last_of_char;
  } col_item_t;

  // classified character, as queued between front and back
  typedef struct packed {
    glyph_t cols;
    logic   eos;
  } glyph_item_t;

  // five columns, first column in the low bits
  function automatic glyph_t cols5(input glyph_col_t c0, input glyph_col_t c1,
                                   input glyph_col_t c2, input glyph_col_t c3,
                                   input glyph_col_t c4);
    return {c4, c3, c2, c1, c0};
  endfunction

  // font table; codes outside the font give the blank glyph
  function automatic glyph_t glyph_lookup(input logic [7:0] code);
    glyph_t g;
    case (code)
      8'h20: g = cols5(7'h00, 7'h00, 7'h00, 7'h00, 7'h00); // space
      8'h30: g = cols5(7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E);
      8'h31: g = cols5(7'h00, 7'h42, 7'h7F, 7'h40, 7'h00);
      8'h32: g = cols5(7'h42, 7'h61, 7'h51, 7'h49, 7'h46);
      8'h33: g = cols5(7'h21, 7'h41, 7'h45, 7'h4B, 7'h31);
      8'h34: g = cols5(7'h18, 7'h14, 7'h12, 7'h7F, 7'h10);
      8'h35: g = cols5(7'h27, 7'h45, 7'h45, 7'h45, 7'h39);
      8'h36: g = cols5(7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30);
      8'h37: g = cols5(7'h01, 7'h71, 7'h09, 7'h05, 7'h03);
      8'h38: g = cols5(7'h36, 7'h49, 7'h49, 7'h49, 7'h36);
      8'h39: g = cols5(7'h06, 7'h49, 7'h49, 7'h29, 7'h1E);
      8'h41: g = cols5(7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E);
      8'h42: g = cols5(7'h7F, 7'h49, 7'h49, 7'h49, 7'h36);
      8'h43: g = cols5(7'h3E, 7'h41, 7'h41, 7'h41, 7'h22);
      8'h44: g = cols5(7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C);
      8'h45: g = cols5(7'h7F, 7'h49, 7'h49, 7'h49, 7'h41);
      8'h46: g = cols5(7'h7F, 7'h09, 7'h09, 7'h09, 7'h01);
      8'h47: g = cols5(7'h3E, 7'h41, 7'h49, 7'h49, 7'h7A);
      8'h48: g = cols5(7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F);
      8'h49: g = cols5(7'h00, 7'h41, 7'h7F, 7'h41, 7'h00);
      8'h4A: g = cols5(7'h20, 7'h40, 7'h41, 7'h3F, 7'h01);
      8'h4B: g = cols5(7'h7F, 7'h08, 7'h14, 7'h22, 7'h41);
      8'h4C: g = cols5(7'h7F, 7'h40, 7'h40, 7'h40, 7'h40);
      8'h4D: g = cols5(7'h7F, 7'h02, 7'h04, 7'h02, 7'h7F);
      8'h4E: g = cols5(7'h7F, 7'h04, 7'h08, 7'h10, 7'h7F);
      8'h4F: g = cols5(7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E);
      8'h50: g = cols5(7'h7F, 7'h09, 7'h09, 7'h09, 7'h06);
      8'h51: g = cols5(7'h3E, 7'h41, 7'h51, 7'h21, 7'h5E);
      8'h52: g = cols5(7'h7F, 7'h09, 7'h19, 7'h29, 7'h46);
      8'h53: g = cols5(7'h46, 7'h49, 7'h49, 7'h49, 7'h31);
      8'h54: g = cols5(7'h01, 7'h01, 7'h7F, 7'h01, 7'h01);
      8'h55: g = cols5(7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F);
      8'h56: g = cols5(7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F);
      8'h57: g = cols5(7'h7F, 7'h20, 7'h18, 7'h20, 7'h7F);
      8'h58: g = cols5(7'h63, 7'h14, 7'h08, 7'h14, 7'h63);
      8'h59: g = cols5(7'h03, 7'h04, 7'h78, 7'h04, 7'h03);
      8'h5A: g = cols5(7'h61, 7'h51, 7'h49, 7'h45, 7'h43);
      8'h3A: g = cols5(7'h00, 7'h36, 7'h36, 7'h00, 7'h00); // colon
      8'h25: g = cols5(7'h62, 7'h64, 7'h08, 7'h13, 7'h23); // percent
      8'h2D: g = cols5(7'h08, 7'h08, 7'h08, 7'h08, 7'h08); // minus
      8'h2E: g = cols5(7'h00, 7'h60, 7'h60, 7'h00, 7'h00); // period
      default: g = '0;
    endcase
    return g;
  endfunction

  // each glyph row doubled into two adjacent column bits
  function automatic logic [2*GLYPH_ROWS-1:0] stretch_column(input glyph_col_t src);
    logic [2*GLYPH_ROWS-1:0] v;
    v = '0;
    for (int b = 0; b < GLYPH_ROWS; b++) begin
      v[2*b]   = src[b];
      v[2*b+1] = src[b];
    end
    return v;
  endfunction

endpackage

@@ hw/rtl/glyph_column_generator.sv @@
// Glyph column generator: an accepted character is registered in the front stage, then
// in the queue; the back-stage column walker gives up to 6 columns per character, one per
// cycle unless the result register is stalled (fewer when double-height truncates).
// A 2-entry queue separates glyph lookup from the column walker.
// Synchronous reset empties the stages and queue, clears the column counter and
// selects normal mode.
`timescale 1ns / 1ps

module glyph_column_generator (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                char_valid,
  output logic                char_ready,
  input  gcg_pkg::char_item_t char_item,
  output logic                col_valid,
  input  logic                col_ready,
  output gcg_pkg::col_item_t  col_item
);
  import gcg_pkg::*;

  logic        push_valid;
  logic        push_ready;
  glyph_item_t push_item;
  logic        head_valid;
  logic        pop;
  glyph_item_t head_item;

  // glyph lookup
  gcg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_item  (char_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // decoupling queue
  gcg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .head_valid (head_valid),
    .pop        (pop),
    .head_item  (head_item)
  );

  // column walker and result register
  gcg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .col_valid  (col_valid),
    .col_ready  (col_ready),
    .col_item   (col_item)
  );

endmodule

@@ hw/rtl/gcg_front.sv @@
// front stage: accepts characters and looks up their glyphs
`timescale 1ns / 1ps

module gcg_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  output logic                char_ready,
  input  gcg_pkg::char_item_t char_item,
  output logic                push_valid,
  input  logic                push_ready,
  output gcg_pkg::glyph_item_t push_item
);
  import gcg_pkg::*;

  logic        stage_valid;
  glyph_item_t stage_item;

  // stage frees up when empty or when the queue takes its item
  assign char_ready = !stage_valid || push_ready;
  assign push_valid = stage_valid;
  assign push_item  = stage_item;

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (char_valid && char_ready) begin
      stage_valid <= 1'b1;
    end else if (push_ready) begin
      stage_valid <= 1'b0;
    end
  end

  // classified item payload
  always_ff @(posedge clk) begin
    if (char_valid && char_ready) begin
      stage_item.cols <= glyph_lookup(char_item.char_code);
      stage_item.eos  <= char_item.end_of_string;
    end
  end

endmodule

@@ hw/rtl/gcg_queue.sv @@
// short queue of glyph items between front and back
`timescale 1ns / 1ps

module gcg_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  gcg_pkg::glyph_item_t push_item,
  output logic                 head_valid,
  input  logic                 pop,
  output gcg_pkg::glyph_item_t head_item
);
  import gcg_pkg::*;

  glyph_item_t       entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QLVL_W-1:0] level;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (level != QLVL_W'(QUEUE_DEPTH));
  assign head_valid = (level != '0);
  assign head_item  = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        level <= level + 1'b1;
      end else if (do_pop && !do_push) begin
        level <= level - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

@@ hw/rtl/gcg_back.sv @@
// back stage: walks each glyph's columns and drives the result register
`timescale 1ns / 1ps
`include "glyph_column_generator_assert.svh"

module gcg_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  input  logic                 head_valid,
  input  gcg_pkg::glyph_item_t head_item,
  output logic                 pop,
  output logic                 col_valid,
  input  logic                 col_ready,
  output gcg_pkg::col_item_t   col_item
);
  import gcg_pkg::*;

  logic                    double_height;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic [CNT_W-1:0]        count_adv;
  logic [CNT_W:0]          count_inc;
  logic [COL_W-1:0]        col;
  logic [COL_W-1:0]        col_next;
  logic                    out_valid;
  col_item_t               out_item;
  logic                    advance;
  logic                    step;
  logic                    skip;
  logic                    emit;
  logic                    is_spacer;
  logic                    is_last;
  glyph_col_t              gcol;
  logic [2*GLYPH_ROWS-1:0] tall;
  col_item_t               new_item;

  assign col_valid = out_valid;
  assign col_item  = out_item;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      double_height <= 1'b0;
    end else if (cfg_we) begin
      double_height <= cfg_wdata;
    end
  end

  // column step control
  assign advance   = !out_valid || col_ready;
  assign step      = head_valid && advance;
  assign skip      = double_height && (count >= CNT_W'(LINE_COLUMNS));
  assign emit      = step && !skip;
  assign count_inc = {1'b0, count} + 1'b1;
  assign is_spacer = (col == COL_W'(GLYPH_WIDTH));
  assign is_last   = is_spacer ||
                     (double_height && (count_inc >= (CNT_W + 1)'(LINE_COLUMNS)));
  assign pop       = step && (skip || is_last);

  // normal mode wraps at 256, double mode stops at the line limit
  always_comb begin
    if (double_height) begin
      count_adv = count_inc[CNT_W-1:0];
    end else begin
      count_adv = CNT_W'(count[7:0] + 8'd1);
    end
  end

  // counter and column pointer next values
  always_comb begin
    count_next = count;
    col_next   = col;
    if (pop && head_item.eos) begin
      count_next = '0;
    end else if (emit) begin
      count_next = count_adv;
    end
    if (pop) begin
      col_next = '0;
    end else if (emit) begin
      col_next = col + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      col   <= '0;
    end else begin
      count <= count_next;
      col   <= col_next;
    end
  end

  // column data for the current position
  always_comb begin
    gcol = '0;
    if (!is_spacer) begin
      gcol = head_item.cols[col];
    end
    tall = stretch_column(gcol);
    new_item.column_index = count[6:0];
    new_item.last_of_char = is_last;
    if (double_height) begin
      new_item.low_byte  = tall[7:0];
      new_item.high_byte = 8'(tall[2*GLYPH_ROWS-1:8]);
    end else begin
      new_item.low_byte  = 8'(gcol);
      new_item.high_byte = 8'h00;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (col_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item <= new_item;
    end
  end

  // checks
  `GCG_ASSERT(a_emit_below_limit, emit && double_height |-> count < CNT_W'(LINE_COLUMNS), "double-height column emitted at line limit")
  `GCG_ASSERT(a_eos_clears_count, pop && head_item.eos |=> count == '0, "counter not cleared after end of string")
  `GCG_ASSERT(a_col_steps, emit && !is_last |=> col == $past(col) + 1'b1, "column pointer did not step")
  `GCG_ASSERT(a_col_in_range, head_valid |-> col <= COL_W'(GLYPH_WIDTH), "column pointer past spacer")

endmodule

@@ dv/tb.sv @@
// self-checking testbench of the glyph column generator
`timescale 1ns / 1ps

module tb;
  import gcg_pkg::*;

  localparam logic MODE_NORMAL   = 1'b0;
  localparam logic MODE_DOUBLE   = 1'b1;
  localparam int   SETTLE_CYCLES = 30;
  localparam int   CYCLE_LIMIT   = 600000;
  localparam int   NUM_PHASES    = 10;
  localparam int   PHASE_ITEMS   = 20;

  // characters that the font knows, all others render blank
  localparam string FONT_CHARS = " 0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ:%-.";

  // expected column items and the column counter they follow from
  class col_scoreboard;
    col_item_t expected_cols[$];
    logic      dbl;
    int        col_count;
    int        fails;

    function new();
      dbl       = MODE_NORMAL;
      col_count = 0;
      fails     = 0;
    endfunction

    // five glyph columns, first column in the top byte
    function logic [39:0] glyph_bits(input logic [7:0] code);
      logic [39:0] f;
      case (code)
        8'h30: f = 40'h3E_51_49_45_3E;
        8'h31: f = 40'h00_42_7F_40_00;
        8'h32: f = 40'h42_61_51_49_46;
        8'h33: f = 40'h21_41_45_4B_31;
        8'h34: f = 40'h18_14_12_7F_10;
        8'h35: f = 40'h27_45_45_45_39;
        8'h36: f = 40'h3C_4A_49_49_30;
        8'h37: f = 40'h01_71_09_05_03;
        8'h38: f = 40'h36_49_49_49_36;
        8'h39: f = 40'h06_49_49_29_1E;
        8'h41: f = 40'h7E_11_11_11_7E;
        8'h42: f = 40'h7F_49_49_49_36;
        8'h43: f = 40'h3E_41_41_41_22;
        8'h44: f = 40'h7F_41_41_22_1C;
        8'h45: f = 40'h7F_49_49_49_41;
        8'h46: f = 40'h7F_09_09_09_01;
        8'h47: f = 40'h3E_41_49_49_7A;
        8'h48: f = 40'h7F_08_08_08_7F;
        8'h49: f = 40'h00_41_7F_41_00;
        8'h4A: f = 40'h20_40_41_3F_01;
        8'h4B: f = 40'h7F_08_14_22_41;
        8'h4C: f = 40'h7F_40_40_40_40;
        8'h4D: f = 40'h7F_02_04_02_7F;
        8'h4E: f = 40'h7F_04_08_10_7F;
        8'h4F: f = 40'h3E_41_41_41_3E;
        8'h50: f = 40'h7F_09_09_09_06;
        8'h51: f = 40'h3E_41_51_21_5E;
        8'h52: f = 40'h7F_09_19_29_46;
        8'h53: f = 40'h46_49_49_49_31;
        8'h54: f = 40'h01_01_7F_01_01;
        8'h55: f = 40'h3F_40_40_40_3F;
        8'h56: f = 40'h1F_20_40_20_1F;
        8'h57: f = 40'h7F_20_18_20_7F;
        8'h58: f = 40'h63_14_08_14_63;
        8'h59: f = 40'h03_04_78_04_03;
        8'h5A: f = 40'h61_51_49_45_43;
        8'h3A: f = 40'h00_36_36_00_00;
        8'h25: f = 40'h62_64_08_13_23;
        8'h2D: f = 40'h08_08_08_08_08;
        8'h2E: f = 40'h00_60_60_00_00;
        default: f = '0;
      endcase
      return f;
    endfunction

    // every row bit becomes two adjacent bits
    function logic [15:0] double_rows(input logic [7:0] col);
      logic [15:0] v;
      v = '0;
      for (int b = 0; b < 7; b++) begin
        v[2*b]   = col[b];
        v[2*b+1] = col[b];
      end
      return v;
    endfunction

    // predict the columns of one accepted character
    function void note_char(input char_item_t it);
      logic [39:0] g;
      logic [7:0]  col;
      logic [15:0] v;
      col_item_t   cols[6];
      int          n;
      g = glyph_bits(it.char_code);
      n = 0;
      for (int c = 0; c <= GLYPH_WIDTH; c++) begin
        if (dbl && col_count >= LINE_COLUMNS) break;
        col = (c < GLYPH_WIDTH) ? g[39-8*c -: 8] : 8'h00;
        cols[n].column_index = col_count[6:0];
        if (!dbl) begin
          cols[n].low_byte     = col;
          cols[n].high_byte    = 8'h00;
          cols[n].last_of_char = (c == GLYPH_WIDTH);
          col_count = (col_count + 1) & 8'hFF;
        end else begin
          v = double_rows(col);
          cols[n].low_byte     = v[7:0];
          cols[n].high_byte    = v[15:8];
          cols[n].last_of_char = 1'b0;
          col_count = col_count + 1;
        end
        n++;
      end
      // truncated characters mark the last column actually sent
      if (dbl && n > 0) cols[n-1].last_of_char = 1'b1;
      for (int k = 0; k < n; k++) expected_cols.push_back(cols[k]);
      if (it.end_of_string) col_count = 0;
    endfunction

    // compare one column item with the oldest expectation
    function void check_col(input col_item_t got);
      col_item_t exp_col;
      if (expected_cols.size() == 0) begin
        $error("column item with none expected: low_byte %0h high_byte %0h column_index %0d",
               got.low_byte, got.high_byte, got.column_index);
        fails++;
        return;
      end
      exp_col = expected_cols.pop_front();
      if (got.low_byte !== exp_col.low_byte) begin
        $error("low_byte mismatch: expected %0h, actual %0h", exp_col.low_byte, got.low_byte);
        fails++;
      end
      if (got.high_byte !== exp_col.high_byte) begin
        $error("high_byte mismatch: expected %0h, actual %0h", exp_col.high_byte,
               got.high_byte);
        fails++;
      end
      if (got.column_index !== exp_col.column_index) begin
        $error("column_index mismatch: expected %0d, actual %0d", exp_col.column_index,
               got.column_index);
        fails++;
      end
      if (got.last_of_char !== exp_col.last_of_char) begin
        $error("last_of_char mismatch: expected %0b, actual %0b", exp_col.last_of_char,
               got.last_of_char);
        fails++;
      end
    endfunction

    function int pending();
      return expected_cols.size();
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic       cfg_wdata;
  logic       char_valid;
  logic       char_ready;
  char_item_t char_item;
  logic       col_valid;
  logic       col_ready = 1'b0;
  col_item_t  col_item;

  col_scoreboard col_board;
  int            cycle_count = 0;
  int            ready_left  = 0;
  int            ready_pick;
  bit            send_burst  = 1'b0;

  glyph_column_generator DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_item  (char_item),
    .col_valid  (col_valid),
    .col_ready  (col_ready),
    .col_item   (col_item)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // run time guard
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // column sink: check accepted items, stall ready in random stretches
  always @(posedge clk) begin
    if (!rst && col_valid && col_ready) col_board.check_col(col_item);
    if (ready_left > 0) begin
      ready_left <= ready_left - 1;
    end else begin
      ready_pick = $urandom_range(0, 99);
      if (ready_pick < 50) begin
        col_ready  <= 1'b1;
        ready_left <= $urandom_range(0, 7);
      end else if (ready_pick < 85) begin
        col_ready  <= 1'b0;
        ready_left <= $urandom_range(0, 2);
      end else if (ready_pick < 95) begin
        col_ready  <= 1'b1;
        ready_left <= $urandom_range(20, 60);
      end else begin
        col_ready  <= 1'b0;
        ready_left <= $urandom_range(10, 40);
      end
    end
  end

  // idle cycles before the next character, mostly short
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // mostly font characters, some arbitrary codes
  function automatic logic [7:0] random_code();
    if ($urandom_range(0, 99) < 80) return FONT_CHARS[$urandom_range(0, 40)];
    return 8'($urandom_range(0, 255));
  endfunction

  // present one character and hold it until accepted
  task automatic send_char(input logic [7:0] code, input logic eos);
    int         gap;
    char_item_t it;
    gap = send_burst ? 0 : pick_gap();
    it.char_code     = code;
    it.end_of_string = eos;
    if (gap > 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_item  <= it;
    @(posedge clk);
    while (!char_ready) @(posedge clk);
    col_board.note_char(it);
  endtask

  // stop sending and let the block run empty
  task automatic drain();
    char_valid <= 1'b0;
    while (col_board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mode register write while idle
  task automatic set_mode(input logic m);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    col_board.dbl = m;
  endtask

  // random strings, the last one left open into the next phase
  task automatic run_phase(input logic m, input int tail_max);
    int sent;
    int len;
    set_mode(m);
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 12);
      for (int k = 0; k < len; k++) send_char(random_code(), k == len - 1);
      sent += len;
    end
    len = $urandom_range(0, tail_max);
    for (int k = 0; k < len; k++) send_char(random_code(), 1'b0);
  endtask

  initial begin
    col_board = new();
    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_wdata  <= 1'b0;
    char_valid <= 1'b0;
    char_item  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // normal mode from reset: space, a digit, a letter, punctuation, codes outside the font
    send_char(8'h20, 1'b0);
    send_char(8'h30, 1'b0);
    send_char(8'h5A, 1'b0);
    send_char(8'h25, 1'b0);
    send_char(8'h2D, 1'b0);
    send_char(8'h2E, 1'b0);
    send_char(8'h3A, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h80, 1'b1);

    // double height: full columns, blank codes
    set_mode(MODE_DOUBLE);
    send_char(8'h4D, 1'b0);
    send_char(8'h57, 1'b0);
    send_char(8'h7F, 1'b0);
    send_char(8'h31, 1'b0);
    send_char(8'hFF, 1'b1);

    // random phases, modes alternate and counters carry across
    for (int p = 0; p < NUM_PHASES; p++) begin
      send_burst = (p % 4 == 3);
      if (p % 2 == 0) run_phase(MODE_NORMAL, 30);
      else run_phase(MODE_DOUBLE, 10);
    end
    send_burst = 1'b0;

    drain();
    if (col_board.fails == 0 && col_board.pending() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ glyph_column_generator.f @@
+incdir+hw/rtl
hw/rtl/gcg_pkg.sv
hw/rtl/gcg_front.sv
hw/rtl/gcg_queue.sv
hw/rtl/gcg_back.sv
hw/rtl/glyph_column_generator.sv
dv/tb.sv
